FILE: rtl/lz_marker_decompressor_defines.svh
// Assertion macros used by the checker file.
`ifndef LZ_MARKER_DECOMPRESSOR_DEFINES_SVH
`define LZ_MARKER_DECOMPRESSOR_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define LZMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lzmd check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define LZMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lzmd check failed");

`endif

FILE: rtl/lzmd_pkg.sv
package lzmd_pkg;

    // Largest chunk the block ever produces.
    localparam int MAX_CHUNK = 256;
    // Results one item may cause, at most.
    localparam int MAX_RESULTS = 64;

    // Token decoder phases.
    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_BODY         = 3'd1;
    localparam logic [2:0] PH_AFTER_MARKER = 3'd2;
    localparam logic [2:0] PH_LENGTH       = 3'd3;
    localparam logic [2:0] PH_OFFSET       = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] byte_count;
        logic       last_of_chunk;
        logic       decode_error;
        logic [8:0] chunk_length;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic rd;
        logic wr;
        logic emit;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic copy_go;
        logic left_one;
        logic pack_full;
        logic pack_any;
        logic end_flag;
        logic slot_free;
    } t_status;

endpackage

FILE: rtl/lzmd_ctrl.sv
module lzmd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lzmd_pkg::t_status i_status,
    output lzmd_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_WR    = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Sequencing of one item: decode, copy byte by byte, final flush.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_status.copy_go ? S_RD : S_FLUSH;
                end
            end
            S_RD: begin
                if (i_status.pack_full) begin
                    o_cmd.emit = i_status.slot_free;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_status.left_one ? S_FLUSH : S_RD;
            end
            S_FLUSH: begin
                if (i_status.pack_any || i_status.end_flag) begin
                    if (i_status.slot_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = i_status.end_flag;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/lzmd_datapath.sv
module lzmd_datapath #(
    parameter int WINDOW_BYTES = 256,
    parameter int OUT_LANES    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzmd_pkg::t_in_item   i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [8:0]           i_cfg_data,
    output logic                 o_cfg_ready,
    input  lzmd_pkg::t_cmd       i_cmd,
    output lzmd_pkg::t_status    o_status,
    output logic                 o_out_valid,
    output lzmd_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);

    localparam int PACK_LANES = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);
    localparam int HIST_DEPTH = (WINDOW_BYTES < lzmd_pkg::MAX_CHUNK) ?
                                WINDOW_BYTES : lzmd_pkg::MAX_CHUNK;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CAP_A      = (HIST_DEPTH < lzmd_pkg::MAX_RESULTS * PACK_LANES) ?
                                HIST_DEPTH : lzmd_pkg::MAX_RESULTS * PACK_LANES;
    localparam logic [8:0] CAP_LIMIT = 9'(CAP_A);
    localparam logic [2:0] PACK_CNT  = 3'(PACK_LANES);

    logic [7:0]  r_mem [HIST_DEPTH];
    logic [8:0]  r_cap_cfg;
    logic [8:0]  r_wp,     n_wp;
    logic [7:0]  r_marker, n_marker;
    logic [2:0]  r_phase,  n_phase;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_off,    n_off;
    logic        r_vtl,    n_vtl;
    logic        r_skip,   n_skip;
    logic        r_end;
    logic [8:0]  r_left;
    logic [7:0]  r_rd_data;
    logic [7:0]  r_pack [4];
    logic [2:0]  r_pack_cnt;
    logic        r_out_valid;
    lzmd_pkg::t_out_item r_out;

    logic [8:0]  cap;
    logic        lit_en;
    logic [7:0]  lit_val;
    logic [8:0]  copy_n;
    logic        drop;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic        slot_free;

    assign cap         = (r_cap_cfg > CAP_LIMIT) ? CAP_LIMIT : r_cap_cfg;
    assign o_cfg_ready = 1'b1;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign rd_addr     = ADDR_W'(r_wp - r_off[8:0]);

    // Token decode of the item on the input port.
    always_comb begin
        logic [7:0]  b;
        logic [15:0] f_off;
        logic        f_vtl;
        logic [8:0]  room;
        b        = i_in_data.data_byte;
        n_wp     = r_wp;
        n_marker = r_marker;
        n_phase  = r_phase;
        n_len    = r_len;
        n_off    = r_off;
        n_vtl    = r_vtl;
        n_skip   = r_skip;
        lit_en   = 1'b0;
        lit_val  = b;
        copy_n   = '0;
        drop     = 1'b0;
        f_off    = {r_off[8:0], b[6:0]};
        f_vtl    = r_vtl || (r_off[15:9] != 7'd0);
        room     = (r_wp >= cap) ? 9'd0 : (cap - r_wp);
        if (i_in_data.chunk_start) begin
            n_marker = b;
            n_wp     = '0;
            n_skip   = 1'b0;
            n_vtl    = 1'b0;
            n_len    = '0;
            n_off    = '0;
            n_phase  = lzmd_pkg::PH_BODY;
        end else if (r_phase == lzmd_pkg::PH_IDLE) begin
            drop = 1'b1;
        end else if (!r_skip) begin
            case (r_phase)
                lzmd_pkg::PH_BODY: begin
                    if (b == r_marker) begin
                        n_phase = lzmd_pkg::PH_AFTER_MARKER;
                    end else begin
                        lit_en = 1'b1;
                    end
                end
                lzmd_pkg::PH_AFTER_MARKER: begin
                    if (b == 8'd0) begin
                        lit_en  = 1'b1;
                        lit_val = r_marker;
                        n_phase = lzmd_pkg::PH_BODY;
                    end else begin
                        n_vtl   = 1'b0;
                        n_len   = {9'd0, b[6:0]};
                        n_off   = '0;
                        n_phase = b[7] ? lzmd_pkg::PH_LENGTH : lzmd_pkg::PH_OFFSET;
                    end
                end
                lzmd_pkg::PH_LENGTH: begin
                    n_len = {r_len[8:0], b[6:0]};
                    if (r_len[15:9] != 7'd0) begin
                        n_vtl = 1'b1;
                    end
                    if (!b[7]) begin
                        n_off   = '0;
                        n_phase = lzmd_pkg::PH_OFFSET;
                    end
                end
                lzmd_pkg::PH_OFFSET: begin
                    n_off = f_off;
                    n_vtl = f_vtl;
                    if (!b[7]) begin
                        n_phase = lzmd_pkg::PH_BODY;
                        if (f_vtl || f_off == 16'd0 || f_off > {7'd0, r_wp}) begin
                            n_skip = 1'b1;
                        end else if (r_len > {7'd0, room}) begin
                            copy_n = room;
                            n_skip = 1'b1;
                        end else begin
                            copy_n = r_len[8:0];
                        end
                    end
                end
                default: ;
            endcase
            // A literal that does not fit is an overrun.
            if (lit_en && r_wp >= cap) begin
                lit_en = 1'b0;
                n_skip = 1'b1;
            end
            if (lit_en) begin
                n_wp = r_wp + 9'd1;
            end
        end
        // A chunk end in the middle of a token is a truncation.
        if (!drop && i_in_data.chunk_end && !n_skip && n_phase != lzmd_pkg::PH_BODY) begin
            n_skip = 1'b1;
        end
        if (!drop && i_in_data.chunk_end) begin
            n_phase = lzmd_pkg::PH_IDLE;
        end
    end

    // Status for the controller.
    always_comb begin
        o_status           = '0;
        o_status.copy_go   = (copy_n != 9'd0);
        o_status.left_one  = (r_left == 9'd1);
        o_status.pack_full = (r_pack_cnt == PACK_CNT);
        o_status.pack_any  = (r_pack_cnt != 3'd0);
        o_status.end_flag  = r_end;
        o_status.slot_free = slot_free;
    end

    // History write port: a literal at decode or a copied byte.
    always_comb begin
        mem_we    = (i_cmd.take && lit_en) || i_cmd.wr;
        mem_waddr = r_wp[ADDR_W-1:0];
        mem_wdata = i_cmd.wr ? r_rd_data : lit_val;
    end

    // History window with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Decoder state, copy counter and output packing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg  <= 9'(lzmd_pkg::MAX_CHUNK);
            r_wp       <= '0;
            r_marker   <= '0;
            r_phase    <= lzmd_pkg::PH_IDLE;
            r_len      <= '0;
            r_off      <= '0;
            r_vtl      <= 1'b0;
            r_skip     <= 1'b0;
            r_end      <= 1'b0;
            r_left     <= '0;
            r_pack_cnt <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pack[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_cap_cfg <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_wp     <= n_wp;
                r_marker <= n_marker;
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_off    <= n_off;
                r_vtl    <= n_vtl;
                r_skip   <= n_skip;
                r_end    <= i_in_data.chunk_end && !drop;
                r_left   <= copy_n;
                if (lit_en) begin
                    r_pack[0]  <= lit_val;
                    r_pack_cnt <= 3'd1;
                end
            end
            if (i_cmd.wr) begin
                r_pack[r_pack_cnt[1:0]] <= r_rd_data;
                r_pack_cnt              <= r_pack_cnt + 3'd1;
                r_wp                    <= r_wp + 9'd1;
                r_left                  <= r_left - 9'd1;
            end
            if (i_cmd.emit) begin
                r_pack_cnt <= '0;
                for (int i = 0; i < 4; i++) begin
                    r_pack[i] <= '0;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte0     <= r_pack[0];
            r_out.out_byte1     <= r_pack[1];
            r_out.out_byte2     <= r_pack[2];
            r_out.out_byte3     <= r_pack[3];
            r_out.byte_count    <= r_pack_cnt;
            r_out.last_of_chunk <= i_cmd.last;
            r_out.decode_error  <= r_skip;
            r_out.chunk_length  <= i_cmd.last ? r_wp : 9'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/lz_marker_decompressor.sv
// Channel   Direction  Handshake            Beat
// input     in         i_in_valid/o_in_stall   t_in_item: byte, chunk start, chunk end
// output    out        o_out_valid/i_out_stall t_out_item: up to four bytes, status
// config    in         i_cfg_valid/o_cfg_ready 9-bit output capacity
//
// A literal or marker byte is decoded, then any result is flushed.
// A back-reference is decoded, then copied byte by byte: each copied byte needs a
// history read and then a write to the history memory, each full result is sent
// before the copy goes on, and the last result leaves in the flush state.
// Reset is synchronous and active low; the history memory needs no clearing pass.
// A stall on the output holds the copy once the packing register is full.
module lz_marker_decompressor #(
    parameter int WINDOW_BYTES = 256,
    parameter int OUT_LANES    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lzmd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lzmd_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [8:0]          i_cfg_data
);

    lzmd_pkg::t_cmd    cmd;
    lzmd_pkg::t_status status;

    // Item sequencer.
    lzmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Decoder, history window and result packing.
    lzmd_datapath #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .OUT_LANES    (OUT_LANES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: rtl/lzmd_checker.sv
`include "lz_marker_decompressor_defines.svh"

module lzmd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lzmd_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lzmd_pkg::t_out_item o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [8:0]          i_cfg_data
);

    // A stalled result beat holds.
    `LZMD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Only the closing result reports a chunk length.
    `LZMD_ASSERT_NOW(a_len_last, o_out_valid && !o_out_data.last_of_chunk, o_out_data.chunk_length == 9'd0)

    // An empty result is only the close of a chunk.
    `LZMD_ASSERT_NOW(a_empty_last, o_out_valid && o_out_data.byte_count == 3'd0, o_out_data.last_of_chunk && o_out_data.out_byte0 == 8'd0)

    // The block never accepts two items in back-to-back cycles.
    `LZMD_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind lz_marker_decompressor lzmd_checker u_lzmd_checker (.*);

FILE: bench/lz_marker_decompressor_tb.sv
`timescale 1ns / 1ps

module lz_marker_decompressor_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    lzmd_pkg::t_in_item  i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    lzmd_pkg::t_out_item o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data;

    lz_marker_decompressor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Decoder state mirrored by the predictor.
    logic [7:0] hist_mem [0:255];
    int         wr_pos;
    logic [7:0] marker;
    logic [2:0] phase;
    int         len_acc;
    int         off_acc;
    logic       too_big;
    logic       skipping;
    logic [8:0] capacity_reg;
    logic [7:0] step_bytes [$];

    lzmd_pkg::t_out_item expected_beats [$];
    int         mismatches;
    int         unexpected;
    logic       idle_enable;
    int         hold_cycles;
    logic       sent;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic int eff_capacity();
        int c;
        c = capacity_reg;
        if (c > 256) c = 256;
        return c;
    endfunction

    function automatic bit emit_byte(logic [7:0] v);
        if (wr_pos >= eff_capacity()) begin
            skipping = 1'b1;
            return 1'b0;
        end
        hist_mem[wr_pos] = v;
        step_bytes.push_back(v);
        wr_pos++;
        return 1'b1;
    endfunction

    function automatic int varint_add(int acc, logic [7:0] b);
        if ((acc >> 9) != 0) too_big = 1'b1;
        return ((acc << 7) | (b & 8'h7f)) & 16'hffff;
    endfunction

    function automatic void copy_back();
        int i;
        if (too_big || off_acc == 0 || off_acc > wr_pos) begin
            skipping = 1'b1;
            return;
        end
        for (i = 0; i < len_acc; i++) begin
            if (!emit_byte(hist_mem[wr_pos - off_acc])) return;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        bit ok;
        case (phase)
            lzmd_pkg::PH_BODY: begin
                if (b == marker) phase = lzmd_pkg::PH_AFTER_MARKER;
                else ok = emit_byte(b);
            end
            lzmd_pkg::PH_AFTER_MARKER: begin
                if (b == 8'd0) begin
                    ok = emit_byte(marker);
                    phase = lzmd_pkg::PH_BODY;
                end else begin
                    too_big = 1'b0;
                    len_acc = varint_add(0, b);
                    off_acc = 0;
                    phase = b[7] ? lzmd_pkg::PH_LENGTH : lzmd_pkg::PH_OFFSET;
                end
            end
            lzmd_pkg::PH_LENGTH: begin
                len_acc = varint_add(len_acc, b);
                if (!b[7]) begin
                    off_acc = 0;
                    phase = lzmd_pkg::PH_OFFSET;
                end
            end
            lzmd_pkg::PH_OFFSET: begin
                off_acc = varint_add(off_acc, b);
                if (!b[7]) begin
                    phase = lzmd_pkg::PH_BODY;
                    copy_back();
                end
            end
            default: ;
        endcase
    endfunction

    // Predict the result beats of one accepted input beat.
    function automatic void predict_beat(lzmd_pkg::t_in_item it);
        int nres, k, j;
        lzmd_pkg::t_out_item r;
        step_bytes.delete();
        if (it.chunk_start) begin
            marker = it.data_byte;
            wr_pos = 0;
            skipping = 1'b0;
            too_big = 1'b0;
            len_acc = 0;
            off_acc = 0;
            phase = lzmd_pkg::PH_BODY;
        end else if (phase == lzmd_pkg::PH_IDLE) begin
            return;
        end else if (!skipping) begin
            decode_byte(it.data_byte);
        end
        if (it.chunk_end && !skipping && phase != lzmd_pkg::PH_BODY) skipping = 1'b1;
        nres = (step_bytes.size() + 3) / 4;
        if (it.chunk_end && nres == 0) nres = 1;
        for (k = 0; k < nres; k++) begin
            r = '0;
            for (j = 0; j < 4 && k * 4 + j < step_bytes.size(); j++) begin
                case (j)
                    0: r.out_byte0 = step_bytes[k * 4 + j];
                    1: r.out_byte1 = step_bytes[k * 4 + j];
                    2: r.out_byte2 = step_bytes[k * 4 + j];
                    default: r.out_byte3 = step_bytes[k * 4 + j];
                endcase
                r.byte_count++;
            end
            r.last_of_chunk = it.chunk_end && (k + 1 == nres);
            r.decode_error = skipping;
            r.chunk_length = r.last_of_chunk ? wr_pos[8:0] : 9'd0;
            expected_beats.push_back(r);
        end
        if (it.chunk_end) phase = lzmd_pkg::PH_IDLE;
    endfunction

    // Output stall generator: random idling, optional quiet stretch and long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_enable && ($urandom_range(99) < 24);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        lzmd_pkg::t_out_item exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_beats.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result beat %h", o_out_data);
            end else begin
                exp_beat = expected_beats.pop_front();
                if (o_out_data !== exp_beat) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: expected %h got %h", exp_beat, o_out_data);
                end
            end
        end
    end

    // Send one input beat, predicting on acceptance. Valid stays high after
    // acceptance until the next beat or an idle cycle replaces it.
    task automatic send_beat(logic [7:0] b, logic st, logic en);
        lzmd_pkg::t_in_item it;
        it.data_byte = b;
        it.chunk_start = st;
        it.chunk_end = en;
        while (idle_enable && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        sent = 1'b0;
        while (!sent) begin
            @(posedge i_clk);
            if (!o_in_stall) sent = 1'b1;
        end
        predict_beat(it);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        // A beat that produces no result may still be in flight.
        while (n < 150) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_capacity(logic [8:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        sent = 1'b0;
        while (!sent) begin
            @(posedge i_clk);
            if (o_cfg_ready) sent = 1'b1;
        end
        i_cfg_valid <= 1'b0;
        capacity_reg = v;
    endtask

    // Directed: literals, escaped marker, copies, errors, restart.
    task automatic test_directed();
        send_beat(8'h55, 1'b0, 1'b1);          // ignored while idle
        send_beat(8'hff, 1'b1, 1'b1);          // marker-only chunk
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h80, 1'b0, 1'b0);
        send_beat(8'h7f, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);          // escaped marker
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);          // copy len 5 off 2
        send_beat(8'h05, 1'b0, 1'b0);
        send_beat(8'h02, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);          // zero length, off 1
        send_beat(8'h80, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        send_beat(8'h10, 1'b1, 1'b0);          // bad offset zero
        send_beat(8'h01, 1'b0, 1'b0);
        send_beat(8'h10, 1'b0, 1'b0);
        send_beat(8'h02, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h33, 1'b0, 1'b1);
        send_beat(8'h10, 1'b1, 1'b0);          // restart drops open chunk
        send_beat(8'h10, 1'b1, 1'b0);
        send_beat(8'h10, 1'b0, 1'b1);          // truncated token
    endtask

    // Long copies past capacity.
    task automatic test_overrun();
        send_beat(8'hcc, 1'b1, 1'b0);
        send_beat(8'h01, 1'b0, 1'b0);
        send_beat(8'hcc, 1'b0, 1'b0);
        send_beat(8'h81, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        send_beat(8'hcc, 1'b1, 1'b0);
        send_beat(8'h42, 1'b0, 1'b0);
        send_beat(8'hcc, 1'b0, 1'b0);
        send_beat(8'h82, 1'b0, 1'b0);
        send_beat(8'h7f, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        send_beat(8'hcc, 1'b1, 1'b0);          // literals only
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
    endtask

    // Random chunks, mostly well formed, with some noise.
    task automatic test_random(int items);
        int n, len;
        logic [7:0] mk, b;
        n = 0;
        while (n < items) begin
            mk = 8'($urandom);
            send_beat(mk, 1'b1, 1'b0);
            n++;
            len = $urandom_range(6, 2);
            repeat (len) begin
                case ($urandom_range(9))
                    0, 1: begin
                        send_beat(mk, 1'b0, 1'b0);
                        send_beat($urandom_range(1) ? 8'h00 : 8'h01, 1'b0, 1'b0);
                        if (phase == lzmd_pkg::PH_OFFSET)
                            send_beat(8'($urandom_range(wr_pos + 1)), 1'b0, 1'b0);
                        n += 2;
                    end
                    2, 3: begin
                        send_beat(mk, 1'b0, 1'b0);
                        send_beat($urandom_range(1) ? 8'h81 : 8'($urandom_range(40, 1)),
                                  1'b0, 1'b0);
                        if (phase == lzmd_pkg::PH_LENGTH)
                            send_beat(8'($urandom_range(127)), 1'b0, 1'b0);
                        if (phase == lzmd_pkg::PH_OFFSET)
                            send_beat(8'($urandom_range(wr_pos + 1)), 1'b0, 1'b0);
                        n += 3;
                    end
                    4: begin
                        send_beat(8'($urandom), 1'b0, 1'b0);
                        n++;
                    end
                    default: begin
                        b = 8'($urandom);
                        if (b == mk) b = ~mk;
                        send_beat(b, 1'b0, 1'b0);
                        n++;
                    end
                endcase
            end
            send_beat(8'($urandom), $urandom_range(9) == 0, 1'b1);
            n++;
        end
    endtask

    // Hold the output for a long stretch while input is offered.
    task automatic test_backpressure();
        hold_cycles = 400;
        test_random(8);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        idle_enable = 1'b1;
        hold_cycles = 0;
        mismatches = 0;
        unexpected = 0;
        wr_pos = 0;
        marker = '0;
        phase = lzmd_pkg::PH_IDLE;
        len_acc = 0;
        off_acc = 0;
        too_big = 1'b0;
        skipping = 1'b0;
        capacity_reg = 9'd256;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overrun();
        write_capacity(9'd1);
        test_overrun();
        write_capacity(9'd0);
        test_random(5);
        write_capacity(9'd511);
        test_random(5);
        write_capacity(9'd20);
        idle_enable = 1'b0;
        test_random(10);
        idle_enable = 1'b1;
        write_capacity(9'd256);
        test_backpressure();

        wait_drained();
        if (mismatches == 0 && unexpected == 0 && expected_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
